// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_ALWAYS(lbl, clk, rstn, cond)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/tbe_pkg.sv
// Types, constants and classification helpers for the brace escape encoder.
// No dependencies.
`default_nettype none
package tbe_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
    localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] ASCII_LIMIT = 8'd128;
    localparam logic [7:0] HUNDRED  = 8'd100;
    localparam logic [7:0] TWO_HUNDRED = 8'd200;
    localparam logic [7:0] TEN      = 8'd10;
    // round(2^11 / 10), exact for quotients of 0..179
    localparam logic [7:0] RECIP_TEN = 8'd205;

    // one queued job: the slots the back end walks through
    typedef struct packed {
        logic       pre_en;     // brace before the main char
        logic       pre_open;   // 1: '{', 0: '}'
        logic       esc;        // tens and units follow
        logic       post_en;    // closing '}' at the end
        logic [7:0] main_char;  // passed byte or hundreds digit
        logic [3:0] tens;
        logic [3:0] units;
    } t_job;

    typedef enum logic [2:0] {
        SL_PRE,
        SL_MAIN,
        SL_TENS,
        SL_UNITS,
        SL_POST
    } t_slot;

    function automatic logic is_printable(input logic [7:0] b);
        logic r;
        r = 1'b0;
        if (b < ASCII_LIMIT) begin
            if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
            if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
            if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
            case (b)
                8'h20, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h2C,
                8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3D, 8'h3F: r = 1'b1;
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tbe_front.sv
// Front end: accepts input beats, classifies bytes, splits escaped bytes
// into decimal digits and tracks the open escape group. Uses tbe_pkg.
`default_nettype none
module tbe_front
    import tbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_string,
    input  wire logic       i_full,
    output logic            o_stall,
    output logic            o_push,
    output t_job            o_job
);

    logic       r_escape_open;
    logic       n_escape_open;
    logic       w_print;
    logic [1:0] w_hund;
    logic [7:0] w_rem;
    logic [14:0] w_prod;
    logic [3:0] w_tens;
    logic [7:0] w_tens_x10;
    logic [7:0] w_units;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign w_print = is_printable(i_in_byte);

    // hundreds by compare, tens by reciprocal multiply, units by subtract
    always_comb begin
        if (i_in_byte >= TWO_HUNDRED) begin
            w_hund = 2'd2;
            w_rem  = i_in_byte - TWO_HUNDRED;
        end else if (i_in_byte >= HUNDRED) begin
            w_hund = 2'd1;
            w_rem  = i_in_byte - HUNDRED;
        end else begin
            w_hund = 2'd0;
            w_rem  = i_in_byte;
        end
        w_prod     = 15'(w_rem[6:0]) * 15'(RECIP_TEN);
        w_tens     = w_prod[14:11];
        w_tens_x10 = 8'(w_tens * TEN);
        w_units    = w_rem - w_tens_x10;
    end

    always_comb begin
        o_job.pre_en    = w_print ? r_escape_open : !r_escape_open;
        o_job.pre_open  = !w_print;
        o_job.esc       = !w_print;
        o_job.post_en   = !w_print && i_end_of_string;
        o_job.main_char = w_print ? i_in_byte : (CH_ZERO + {6'd0, w_hund});
        o_job.tens      = w_tens;
        o_job.units     = w_units[3:0];
        n_escape_open   = o_push ? (!w_print && !i_end_of_string) : r_escape_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_open <= 1'b0;
        end else begin
            r_escape_open <= n_escape_open;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tbe_queue.sv
// Short job queue between front and back end, register based.
// Uses tbe_pkg for the job type.
`default_nettype none
module tbe_queue
    import tbe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  t_job                            i_job,
    input  wire logic                       i_pop,
    output t_job                            o_head,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push, w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/tbe_back.sv
// Back end: walks the slots of the head job into the output register,
// one character per cycle while a job waits and the output does not stall. Uses tbe_pkg.
`default_nettype none
module tbe_back
    import tbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  t_job            i_job,
    input  wire logic       i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_out_char,
    output logic            o_run_last
);

    t_slot      r_slot, n_slot;
    t_slot      w_cur;
    t_slot      w_next;
    logic       w_done;
    logic       w_load_ok;
    logic       w_fire;
    logic [7:0] w_char;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    assign w_load_ok = !r_out_valid || !i_stall;
    assign w_fire    = i_job_valid && w_load_ok;
    // a job without a leading brace starts at its main char
    assign w_cur     = (r_slot == SL_PRE && !i_job.pre_en) ? SL_MAIN : r_slot;

    // slot sequencing
    always_comb begin
        w_next = SL_PRE;
        w_done = 1'b0;
        case (w_cur)
            SL_PRE:   w_next = SL_MAIN;
            SL_MAIN: begin
                if (i_job.esc) begin
                    w_next = SL_TENS;
                end else if (i_job.post_en) begin
                    w_next = SL_POST;
                end else begin
                    w_done = 1'b1;
                end
            end
            SL_TENS:  w_next = SL_UNITS;
            SL_UNITS: begin
                if (i_job.post_en) begin
                    w_next = SL_POST;
                end else begin
                    w_done = 1'b1;
                end
            end
            SL_POST:  w_done = 1'b1;
            default:  w_done = 1'b1;
        endcase
        if (!w_fire) begin
            n_slot = r_slot;
        end else if (w_done) begin
            n_slot = SL_PRE;
        end else begin
            n_slot = w_next;
        end
    end

    // character of the current slot
    always_comb begin
        case (w_cur)
            SL_PRE:   w_char = i_job.pre_open ? CH_OPEN : CH_CLOSE;
            SL_MAIN:  w_char = i_job.main_char;
            SL_TENS:  w_char = CH_ZERO + {4'd0, i_job.tens};
            SL_UNITS: w_char = CH_ZERO + {4'd0, i_job.units};
            SL_POST:  w_char = CH_CLOSE;
            default:  w_char = CH_CLOSE;
        endcase
        o_pop = w_fire && w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= SL_PRE;
            r_out_valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (w_load_ok) begin
                r_out_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_char <= w_char;
            r_out_last <= w_done;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_run_last = r_out_last;

endmodule
`default_nettype wire

// File: rtl/t61_brace_escape_encoder_core.sv
// Brace escape encoder top level: front end, job queue, back end.
// An accepted beat is written to the job queue; its first char is then registered in the output register.
// Throughput: one output char per cycle from the back-end slot sequencer while jobs
// are queued and i_stall does not hold it; an item produces 1 to 5 chars, escaped bytes 3 to 5.
// Input stalls only when the job queue is full.
// Reset: synchronous, clears the group flag, queue pointers, slot, out valid.
`default_nettype none
`include "assert_macros.svh"
module t61_brace_escape_encoder_core
    import tbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_string,
    output logic            o_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_char,
    output logic            o_run_last,
    input  wire logic       i_stall
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          w_push_job, w_head_job;
    logic          w_push, w_pop, w_empty, w_full;
    logic [CW-1:0] w_count;

    tbe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_full          (w_full),
        .o_stall         (o_stall),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    tbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head_job),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_count)
    );

    tbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_head_job),
        .i_stall     (i_stall),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

    // finishing a job always leaves its last char in the output register
    `CHK_NEXT(a_pop_loads_last, i_clk, i_rst_n, w_pop, o_valid && o_run_last)
    // a char taken mid-run is followed at once by the next char of that run
    `CHK_NEXT(a_run_no_gap, i_clk, i_rst_n, o_valid && !i_stall && !o_run_last, o_valid)
    `CHK_ALWAYS(a_queue_bound, i_clk, i_rst_n, w_count <= CW'(QUEUE_DEPTH))

endmodule
`default_nettype wire
